// ===== sv/mtep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and constants shared by the MIDI track event parser modules.
// ----------------------------------------------------------------------------
package mtep_pkg;

	localparam int TIME_WIDTH = 48;
	localparam int FRAC_BITS  = 16;
	localparam int DELTA_W    = 28;
	localparam int FPT_W      = 32;
	localparam int PROD_W     = DELTA_W + FPT_W;
	localparam int EXT_W      = (PROD_W > TIME_WIDTH) ? PROD_W : TIME_WIDTH;

	localparam logic [FPT_W-1:0] FPT_RESET = FPT_W'(65536);

	localparam logic [7:0] STATUS_META   = 8'hff;
	localparam logic [7:0] STATUS_SYSEX  = 8'hf0;
	localparam logic [7:0] STATUS_ESCAPE = 8'hf7;
	localparam logic [3:0] NIB_PROGRAM   = 4'hc;
	localparam logic [3:0] NIB_PRESSURE  = 4'hd;

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_META_TYPE,
		PH_META_LEN,
		PH_META_DATA,
		PH_DATA1,
		PH_DATA2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_EVENT = 2'd0,
		KIND_SYSEX = 2'd1,
		KIND_TRUNC = 2'd2,
		KIND_LONG  = 2'd3
	} kind_t;

	// what the parse stage hands to the timestamp stage
	typedef struct packed {
		logic                  has_res;
		kind_t                 kind;
		logic [7:0]            status;
		logic [7:0]            data1;
		logic [7:0]            data2;
		logic                  add_delta;
		logic                  clear;
		logic [TIME_WIDTH-1:0] delta_frames;
	} parse_res_t;

endpackage

// ===== sv/mtep_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_parser
// Byte-level track parser: delta decode, delta scaling, event assembly.
// ----------------------------------------------------------------------------
module mtep_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [7:0]                   in_byte,
	input  logic                         in_last,
	input  logic                         cfg_valid,
	input  logic [mtep_pkg::FPT_W-1:0]   cfg_data,
	input  logic                         next_ready,
	output logic                         res_valid_s1,
	output mtep_pkg::parse_res_t         res_s1
);
	import mtep_pkg::*;

	phase_t             phase_q, phase_n, phase_step;
	logic [DELTA_W-1:0] acc_q, acc_n, acc_shift;
	logic [1:0]         cnt_q, cnt_n;
	logic [7:0]         status_q, status_n;
	logic [7:0]         data1_q, data1_n;
	logic [7:0]         meta_q, meta_n, meta_dec;
	logic               hold_q, hold_n;
	logic [FPT_W-1:0]   fpt_q;
	logic               accept, advance, err_now;
	parse_res_t         res_n;
	logic [PROD_W-1:0]  prod;
	logic [EXT_W-1:0]   prod_ext;
	logic               short_event;

	assign advance  = res_valid_s1 && next_ready;
	assign in_ready = !res_valid_s1 || next_ready;
	assign accept   = in_valid && in_ready;

	assign acc_shift   = {acc_q[DELTA_W-8:0], in_byte[6:0]};
	assign meta_dec    = meta_q - 8'd1;
	assign short_event = (status_q[7:4] == NIB_PROGRAM) || (status_q[7:4] == NIB_PRESSURE);

	assign prod     = PROD_W'(acc_shift) * PROD_W'(fpt_q);
	assign prod_ext = EXT_W'(prod) >> FRAC_BITS;

	// phase after this byte, before any track-end clear
	always_comb begin
		phase_step = phase_q;
		if (!hold_q) begin
			unique case (phase_q)
				PH_DELTA: begin
					if (!in_byte[7]) phase_step = PH_STATUS;
				end
				PH_STATUS: begin
					if (in_byte == STATUS_META) begin
						phase_step = PH_META_TYPE;
					end else if (in_byte != STATUS_SYSEX && in_byte != STATUS_ESCAPE) begin
						phase_step = PH_DATA1;
					end
				end
				PH_META_TYPE: phase_step = PH_META_LEN;
				PH_META_LEN: begin
					phase_step = (in_byte == 8'd0) ? PH_DELTA : PH_META_DATA;
				end
				PH_META_DATA: begin
					if (meta_dec == 8'd0) phase_step = PH_DELTA;
				end
				PH_DATA1: begin
					phase_step = short_event ? PH_DELTA : PH_DATA2;
				end
				PH_DATA2: phase_step = PH_DELTA;
				default: phase_step = PH_DELTA;
			endcase
		end
	end

	assign phase_n = in_last ? PH_DELTA : phase_step;

	// datapath and results
	always_comb begin
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		status_n = status_q;
		data1_n  = data1_q;
		meta_n   = meta_q;
		hold_n   = hold_q;
		err_now  = 1'b0;
		res_n    = '0;
		res_n.kind         = KIND_EVENT;
		res_n.delta_frames = prod_ext[TIME_WIDTH-1:0];
		if (!hold_q) begin
			unique case (phase_q)
				PH_DELTA: begin
					acc_n = acc_shift;
					if (in_byte[7]) begin
						if (cnt_q == 2'd3) begin
							res_n.has_res = 1'b1;
							res_n.kind    = KIND_LONG;
							err_now       = 1'b1;
							hold_n        = 1'b1;
						end else begin
							cnt_n = cnt_q + 2'd1;
						end
					end else begin
						res_n.add_delta = 1'b1;
						acc_n = '0;
						cnt_n = '0;
					end
				end
				PH_STATUS: begin
					if (in_byte == STATUS_SYSEX || in_byte == STATUS_ESCAPE) begin
						res_n.has_res = 1'b1;
						res_n.kind    = KIND_SYSEX;
						err_now       = 1'b1;
						hold_n        = 1'b1;
					end else if (in_byte != STATUS_META) begin
						status_n = in_byte;
					end
				end
				PH_META_TYPE: ;
				PH_META_LEN:  meta_n = in_byte;
				PH_META_DATA: meta_n = meta_dec;
				PH_DATA1: begin
					data1_n = in_byte;
					if (short_event) begin
						res_n.has_res = 1'b1;
						res_n.status  = status_q;
						res_n.data1   = in_byte;
					end
				end
				PH_DATA2: begin
					res_n.has_res = 1'b1;
					res_n.status  = status_q;
					res_n.data1   = data1_q;
					res_n.data2   = in_byte;
				end
				default: ;
			endcase
		end
		if (in_last) begin
			// incomplete delta or event at track end
			if (!hold_n && !err_now && !(phase_step == PH_DELTA && cnt_n == 2'd0)) begin
				res_n.has_res = 1'b1;
				res_n.kind    = KIND_TRUNC;
				res_n.status  = '0;
				res_n.data1   = '0;
				res_n.data2   = '0;
			end
			res_n.clear = 1'b1;
			acc_n    = '0;
			cnt_n    = '0;
			status_n = '0;
			data1_n  = '0;
			meta_n   = '0;
			hold_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_DELTA;
			acc_q        <= '0;
			cnt_q        <= '0;
			status_q     <= '0;
			data1_q      <= '0;
			meta_q       <= '0;
			hold_q       <= 1'b0;
			fpt_q        <= FPT_RESET;
			res_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) fpt_q <= cfg_data;
			if (accept) begin
				phase_q  <= phase_n;
				acc_q    <= acc_n;
				cnt_q    <= cnt_n;
				status_q <= status_n;
				data1_q  <= data1_n;
				meta_q   <= meta_n;
				hold_q   <= hold_n;
				res_valid_s1 <= 1'b1;
			end else if (advance) begin
				res_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_s1 <= res_n;
	end

endmodule

// ===== sv/mtep_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_timer
// Sample-frame clock accumulation and the output register.
// ----------------------------------------------------------------------------
module mtep_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              res_valid_s1,
	input  mtep_pkg::parse_res_t              res_s1,
	output logic                              ready,
	output logic                              out_valid,
	input  logic                              out_ready,
	output mtep_pkg::kind_t                   out_kind,
	output logic [7:0]                        out_status,
	output logic [7:0]                        out_data1,
	output logic [7:0]                        out_data2,
	output logic [mtep_pkg::TIME_WIDTH-1:0]   out_time
);
	import mtep_pkg::*;

	logic [TIME_WIDTH-1:0] time_q, time_sum;
	logic                  advance;

	assign ready    = !out_valid || out_ready;
	assign advance  = res_valid_s1 && ready;
	assign time_sum = time_q + (res_s1.add_delta ? res_s1.delta_frames : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (advance) begin
				time_q    <= res_s1.clear ? '0 : time_sum;
				out_valid <= res_s1.has_res;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_s1.has_res) begin
			out_kind   <= res_s1.kind;
			out_status <= res_s1.status;
			out_data1  <= res_s1.data1;
			out_data2  <= res_s1.data2;
			out_time   <= time_sum;
		end
	end

endmodule

// ===== sv/midi_track_event_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Turns track body bytes into timestamped channel events and error reports.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one track body byte per request, tlast on the last byte of a
//   track. m_* carries at most one result per input byte: tuser is the kind
//   (event, sysex unsupported, track truncated, delta too long), tdata the
//   status, data bytes and the sample-frame time of the event.
//   cfg_* writes frames_per_tick (16.16 unsigned); write it only while idle.
//   Throughput is one byte per cycle while m_tready is high. A result
//   passes through the parse stage, loaded when its byte is accepted,
//   where the 28x32 delta scaling multiply sits, and then the output
//   register, loaded from it through the timestamp adder.
//   When m_tready is low the result stays in the output register; the parse
//   stage still holds one further byte, then s_tready drops.
//   After reset, and after every tlast byte, the parser and the frame clock
//   start from zero; frames_per_tick resets to 1.0 and keeps its value
//   across tracks. After a sysex or too-long delta, bytes are dropped up to
//   the end of the track.
// ----------------------------------------------------------------------------
module midi_track_event_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // track_byte[7:0]
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // event_status, event_data1, event_data2, event_time[47:0]
	output logic [1:0]  m_tuser,   // kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import mtep_pkg::*;

	parse_res_t            res_s1;
	logic                  res_valid_s1;
	logic                  timer_ready;
	kind_t                 out_kind;
	logic [7:0]            out_status, out_data1, out_data2;
	logic [TIME_WIDTH-1:0] out_time;

	assign cfg_ready = 1'b1;

	mtep_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_byte      (s_tdata),
		.in_last      (s_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.next_ready   (timer_ready),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1)
	);

	mtep_timer u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_valid_s1 (res_valid_s1),
		.res_s1       (res_s1),
		.ready        (timer_ready),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_kind     (out_kind),
		.out_status   (out_status),
		.out_data1    (out_data1),
		.out_data2    (out_data2),
		.out_time     (out_time)
	);

	assign m_tuser = out_kind;
	assign m_tdata = {out_time, out_data2, out_data1, out_status};

	// input stalls only behind a held parse-stage item
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (res_valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a blocked pipeline");

	// error reports carry no event bytes
	a_err_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s1 && res_s1.has_res && res_s1.kind != KIND_EVENT) |->
		(res_s1.status == 8'd0 && res_s1.data1 == 8'd0 && res_s1.data2 == 8'd0))
		else $error("error report with nonzero event bytes");

	// a moving parse-stage item shows up at the output only if it has a result
	a_out_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s1 && timer_ready) |=> (m_tvalid == $past(res_s1.has_res)))
		else $error("output valid does not follow parse-stage result");

	// a truncation report always closes a track
	a_trunc_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s1 && res_s1.has_res && res_s1.kind == KIND_TRUNC) |-> res_s1.clear)
		else $error("truncation report outside track end");

endmodule
